>>> rtl/core/linear_probe_table_search_macros.svh
// Assertion macros for the linear probe table search block.
// Each macro expands to a concurrent assertion on clk_i in simulation
// and to nothing in synthesis.
`ifndef LINEAR_PROBE_TABLE_SEARCH_MACROS_SVH
`define LINEAR_PROBE_TABLE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset only
`define LPTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lpts assertion failed");
// Checked at every edge, reset included
`define LPTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("lpts assertion failed");
`else
`define LPTS_ASSERT(lbl, prop)
`define LPTS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/core/lpts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpts_pkg
// Types and fixed constants of the linear probe table search block.
// ----------------------------------------------------------------------------
package lpts_pkg;

  // Fixed field widths
  localparam int SlotW = 10;
  localparam int KeyW  = 32;
  // Width for start index reduction: table size up to 2^20 shifted by SlotW-1
  localparam int RedW  = 30;
  localparam logic [3:0] ShiftTop = 4'(SlotW - 1);

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_FIND_KEY   = 2'd1,
    OP_FIND_EMPTY = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_PROBE,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic [SlotW-1:0]        slot_or_start;
    logic signed [KeyW-1:0]  key_value;
    logic                    busy_in;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot_index;
  } rsp_t;

endpackage

>>> rtl/core/lpts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpts_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface lpts_req_if;
  import lpts_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpts_rsp_if;
  import lpts_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/linear_probe_table_search.sv
// Write request: accepted, written in the write state, then back to idle.
// Search request: one slot probed per cycle from the table memory read port;
//   the search ends at the first hit or once every slot has been probed.
// A start index at or beyond TABLE_SLOTS is first reduced in the reduce state.
// After reset the busy bits are cleared in a pass over every slot,
// during which no request is accepted.
`timescale 1ns / 1ps
`include "linear_probe_table_search_macros.svh"
// ----------------------------------------------------------------------------
// linear_probe_table_search
// Open-addressed table of slots (busy bit + 32-bit key) with write, linear
// probe key search and linear probe empty-slot search.
// ----------------------------------------------------------------------------
module linear_probe_table_search #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpts_req_if.sink   req_i,
  lpts_rsp_if.source rsp_o
);
  import lpts_pkg::*;

  localparam int IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CntW = $clog2(TABLE_SLOTS + 1);
  localparam int ExtW = (IdxW > SlotW) ? IdxW : SlotW;
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(TABLE_SLOTS - 1);
  localparam logic [CntW-1:0] SlotsCnt  = CntW'(TABLE_SLOTS);
  localparam logic [RedW-1:0] SlotsRed  = RedW'(TABLE_SLOTS);

  // Table memory: {busy, key}
  logic [KeyW:0] mem_q [TABLE_SLOTS];

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic              busy_q, busy_d;
  logic [SlotW-1:0]  rem_q, rem_d;
  logic [3:0]        sh_q, sh_d;
  logic [IdxW-1:0]   addr_q, addr_d;
  logic [CntW-1:0]   iss_q, iss_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   ridx_q, ridx_d;
  logic [KeyW:0]     rdata_q;
  logic              hit_found_q, hit_found_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  logic              out_valid_q, out_valid_d;
  logic              out_found_q;
  logic [SlotW-1:0]  out_idx_q;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [KeyW:0]     mem_wdata;
  logic              mem_re;
  logic              take;
  logic              out_load;
  logic              req_fire;
  logic [RedW-1:0]   divisor;
  logic [ExtW-1:0]   start_ext;
  logic [ExtW-1:0]   rem_ext;
  logic [ExtW-1:0]   hit_ext;
  logic [IdxW-1:0]   addr_next;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Index conversions between the 10-bit field and the table index
  assign start_ext = ExtW'(req_i.data.slot_or_start);
  assign rem_ext   = ExtW'(rem_d);
  assign hit_ext   = ExtW'(hit_idx_q);
  assign addr_next = (addr_q == LastIdx) ? '0 : addr_q + 1'b1;
  assign divisor   = SlotsRed << sh_q;

  // Probe hit test on the registered read data
  always_comb begin
    if (op_q == OP_FIND_KEY) begin
      take = rdata_q[KeyW] && (rdata_q[KeyW-1:0] == key_q);
    end else begin
      take = !rdata_q[KeyW];
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    busy_d      = busy_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    addr_d      = addr_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    ridx_d      = ridx_q;
    hit_found_d = hit_found_q;
    hit_idx_d   = hit_idx_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = {1'b0, key_q};
    mem_re      = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        addr_d    = addr_next;
        if (addr_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire &&
            (req_i.data.op inside {OP_WRITE, OP_FIND_KEY, OP_FIND_EMPTY})) begin
          op_d   = req_i.data.op;
          key_d  = req_i.data.key_value;
          busy_d = req_i.data.busy_in;
          rem_d  = req_i.data.slot_or_start;
          sh_d   = ShiftTop;
          addr_d = start_ext[IdxW-1:0];
          iss_d  = '0;
          if (RedW'(req_i.data.slot_or_start) >= SlotsRed) begin
            state_d = ST_REDUCE;
          end else if (req_i.data.op == OP_WRITE) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end
      ST_REDUCE: begin
        // One restoring step of start modulo table size per cycle
        if (RedW'(rem_q) >= divisor) begin
          rem_d = rem_q - divisor[SlotW-1:0];
        end
        sh_d = sh_q - 1'b1;
        if (sh_q == '0) begin
          addr_d  = rem_ext[IdxW-1:0];
          state_d = (op_q == OP_WRITE) ? ST_WRITE : ST_PROBE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = {busy_q, key_q};
        state_d   = ST_IDLE;
      end
      ST_PROBE: begin
        // Issue the next slot read while the previous one is tested
        if (iss_q < SlotsCnt) begin
          mem_re = 1'b1;
          addr_d = addr_next;
          iss_d  = iss_q + 1'b1;
          pend_d = 1'b1;
          ridx_d = addr_q;
        end
        if (pend_q && take) begin
          hit_found_d = 1'b1;
          hit_idx_d   = ridx_q;
          state_d     = ST_DONE;
        end else if (pend_q && (iss_q == SlotsCnt)) begin
          hit_found_d = 1'b0;
          hit_idx_d   = '0;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register handshake
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.data.found      = out_found_q;
  assign rsp_o.data.slot_index = out_idx_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      sh_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      addr_q      <= addr_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      sh_q        <= sh_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    busy_q      <= busy_d;
    rem_q       <= rem_d;
    ridx_q      <= ridx_d;
    hit_found_q <= hit_found_d;
    hit_idx_q   <= hit_idx_d;
    if (out_load) begin
      out_found_q <= hit_found_q;
      out_idx_q   <= hit_ext[SlotW-1:0];
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // Searches only read the table
  `LPTS_ASSERT(a_probe_no_write, (state_q == ST_PROBE) |-> !mem_we)
  // A miss always reports slot zero
  `LPTS_ASSERT(a_miss_idx_zero, (out_valid_q && !out_found_q) |-> (out_idx_q == '0))
  // Probe count never passes the table size
  `LPTS_ASSERT(a_iss_bound, iss_q <= SlotsCnt)
  // A new result only comes from the done state
  `LPTS_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q == ST_DONE))

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probe table search block. A short
// table of hand-picked requests runs first, then a couple hundred random
// requests shaped like hash-table traffic (inserts at the first free slot
// after a random hash, lookups starting just below a live slot, deletes,
// plus misses and ignored codes), and last a pass that fills every free
// slot. Each result is checked against the typed row or a bench slot table.
// ----------------------------------------------------------------------------
module tb;
  import lpts_pkg::*;

  localparam int          Slots      = 1024;
  localparam int          RandItems  = 200;
  localparam int          CycleLimit = 10_000_000;
  localparam int          TailCycles = 40;
  localparam logic [1:0]  OP_NONE    = 2'd3;  // unused code, block ignores it

  // One row of the directed table; want is used only where typed is set
  typedef struct {
    logic [1:0]  op;
    logic [9:0]  slot;
    logic [31:0] key;
    logic        busy;
    bit          typed;
    logic        want_found;
    logic [9:0]  want_slot;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lpts_req_if req_ch ();
  lpts_rsp_if rsp_ch ();

  linear_probe_table_search #(
    .TABLE_SLOTS(Slots)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // Bench copy of the slot table
  bit          busy_mem [Slots];
  logic [31:0] key_mem  [Slots];

  rsp_t        pending_rsp [$];
  int          live_slots  [$];
  int          errors      = 0;
  int          cycle_count = 0;
  bit          calm        = 1'b0;

  stim_row_t dir_rows [0:24] = '{
    '{OP_FIND_EMPTY, 10'd0,    32'h0000_0000, 1'b0, 1'b1, 1'b1, 10'd0},
    '{OP_FIND_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 10'd1023},
    '{OP_FIND_KEY,   10'd0,    32'h0000_0000, 1'b0, 1'b1, 1'b0, 10'd0},
    '{OP_FIND_KEY,   10'd1023, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 10'd0},
    '{OP_WRITE,      10'd0,    32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_WRITE,      10'd1023, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_WRITE,      10'd1,    32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_WRITE,      10'd2,    32'h0000_0000, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_FIND_KEY,   10'd0,    32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 10'd0},
    '{OP_FIND_KEY,   10'd0,    32'h8000_0000, 1'b1, 1'b1, 1'b1, 10'd1023},
    '{OP_FIND_KEY,   10'd1,    32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 10'd0},
    '{OP_FIND_EMPTY, 10'd1023, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 10'd3},
    '{OP_FIND_EMPTY, 10'd0,    32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_FIND_KEY,   10'd1023, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 10'd1},
    '{OP_NONE,       10'd5,    32'h1234_5678, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_FIND_EMPTY, 10'd5,    32'h1234_5678, 1'b0, 1'b1, 1'b1, 10'd5},
    '{OP_FIND_KEY,   10'd0,    32'h1234_5678, 1'b1, 1'b1, 1'b0, 10'd0},
    '{OP_WRITE,      10'd1,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 10'd0},
    '{OP_FIND_KEY,   10'd0,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 10'd0},
    '{OP_FIND_EMPTY, 10'd0,    32'h0000_0000, 1'b0, 1'b0, 1'b0, 10'd0},
    '{OP_WRITE,      10'd600,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_FIND_KEY,   10'd3,    32'h0000_0000, 1'b0, 1'b0, 1'b0, 10'd0},
    '{OP_FIND_KEY,   10'd601,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 10'd0},
    '{OP_NONE,       10'd1023, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 10'd0},
    '{OP_FIND_EMPTY, 10'd2,    32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 10'd0}
  };

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Apply one request to the slot table; searches give one lookup result
  function automatic void table_step(input logic [1:0] op, input logic [9:0] slot,
                                     input logic [31:0] key, input logic busy,
                                     output bit has_rsp, output rsp_t lookup);
    int idx;
    has_rsp = 1'b0;
    lookup  = '0;
    case (op)
      OP_WRITE: begin
        busy_mem[slot] = busy;
        key_mem[slot]  = key;
      end
      OP_FIND_KEY, OP_FIND_EMPTY: begin
        has_rsp = 1'b1;
        // linear probe, wrapping, stops at first hit
        for (int step = 0; step < Slots && !lookup.found; step++) begin
          idx = (int'(slot) + step) % Slots;
          if (op == OP_FIND_KEY ? (busy_mem[idx] && key_mem[idx] == key) : !busy_mem[idx])
          begin
            lookup.found      = 1'b1;
            lookup.slot_index = idx[9:0];
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one request; entered and left at a falling edge
  task automatic send_request(input logic [1:0] op, input logic [9:0] slot,
                              input logic [31:0] key, input logic busy,
                              input bit typed, input rsp_t typed_rsp);
    req_t  r;
    rsp_t  lookup;
    bit    has_rsp;
    int    gap;
    gap             = calm ? 0 : $urandom_range(0, 5);
    r.op            = op_e'(op);
    r.slot_or_start = slot;
    r.key_value     = key;
    r.busy_in       = busy;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    table_step(op, slot, key, busy, has_rsp, lookup);
    if (has_rsp) pending_rsp.push_back(typed ? typed_rsp : lookup);
    @(negedge clk);
  endtask

  // Hold off new requests until every pending lookup result is back
  task automatic wait_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // Result side: random stall after each result
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result with none pending, slot", rsp_ch.data.slot_index, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.data.found !== want.found)
          report_mismatch("found", rsp_ch.data.found, want.found);
        if (rsp_ch.data.slot_index !== want.slot_index)
          report_mismatch("slot_index", rsp_ch.data.slot_index, want.slot_index);
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] key_pool [8];
    logic [1:0]  op;
    logic [9:0]  slot;
    logic [31:0] key;
    logic        busy;
    rsp_t        typed_rsp;
    rsp_t        probe_rsp;
    bit          has_rsp;
    int          pick;
    int          sel;
    int          sub;

    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    key_pool[0]  = 32'h0000_0000;
    key_pool[1]  = 32'hFFFF_FFFF;
    key_pool[2]  = 32'h8000_0000;
    key_pool[3]  = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      typed_rsp.found      = dir_rows[i].want_found;
      typed_rsp.slot_index = dir_rows[i].want_slot;
      send_request(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].key,
                   dir_rows[i].busy, dir_rows[i].typed, typed_rsp);
    end
    wait_results();

    // Random hash-table traffic
    for (int n = 0; n < RandItems; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) wait_results();
      sel  = $urandom_range(0, 99);
      slot = 10'($urandom_range(0, Slots - 1));
      key  = $urandom;
      busy = 1'($urandom);
      if (sel < 38) begin
        op  = OP_WRITE;
        sub = $urandom_range(0, 9);
        if (sub <= 6) begin
          // insert at the first free slot after a random hash
          if ($urandom_range(0, 3) == 0) key = key_pool[$urandom_range(0, 7)];
          table_step(OP_FIND_EMPTY, slot, '0, 1'b0, has_rsp, probe_rsp);
          if (probe_rsp.found) slot = probe_rsp.slot_index;
          busy = 1'b1;
          live_slots.push_back(int'(slot));
        end else if (sub <= 8 && live_slots.size() != 0) begin
          // delete a live entry
          slot = 10'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
          busy = 1'b0;
        end
      end else if (sel < 75) begin
        op = OP_FIND_KEY;
        if ($urandom_range(0, 99) < 85 && live_slots.size() != 0) begin
          pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
          if (busy_mem[pick]) key = key_mem[pick];
          slot = 10'((pick - $urandom_range(0, 6) + Slots) % Slots);
        end
      end else if (sel < 95) begin
        op = OP_FIND_EMPTY;
      end else begin
        op = OP_NONE;
      end
      send_request(op, slot, key, busy, 1'b0, '0);
    end
    wait_results();
    calm = 1'b0;

    // Fill every free slot, search the full table, then free one slot and search again
    for (int s = 0; s < Slots; s++) begin
      if (!busy_mem[s]) send_request(OP_WRITE, 10'(s), $urandom, 1'b1, 1'b0, '0);
    end
    send_request(OP_FIND_EMPTY, 10'($urandom_range(0, Slots - 1)), $urandom, 1'b0, 1'b0, '0);
    send_request(OP_FIND_EMPTY, 10'd1023, $urandom, 1'b1, 1'b0, '0);
    pick = $urandom_range(0, Slots - 1);
    send_request(OP_FIND_KEY, 10'($urandom_range(0, Slots - 1)), key_mem[pick], 1'b0,
                 1'b0, '0);
    send_request(OP_FIND_KEY, 10'($urandom_range(0, Slots - 1)), $urandom, 1'b1, 1'b0, '0);
    pick = $urandom_range(0, Slots - 1);
    send_request(OP_WRITE, 10'(pick), $urandom, 1'b0, 1'b0, '0);
    send_request(OP_FIND_EMPTY, 10'($urandom_range(0, Slots - 1)), $urandom, 1'b0, 1'b0, '0);

    wait_results();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> linear_probe_table_search.f
+incdir+rtl/core
rtl/core/lpts_pkg.sv
rtl/core/lpts_if.sv
rtl/core/linear_probe_table_search.sv
tb/tb.sv
